[rtl/core/pwfm_pkg.sv]
// Shared constants and lane product helper for the power-of-two weight MAC row.
`timescale 1ns / 1ps

package pwfm_pkg;

    localparam int LANES = 16;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CODE_LANES = 16;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [7:0] EXP_MASK = 8'h1F;
    localparam int EXP_SHIFT = 23;

    // Weight is +/- 2^e: add e to the exponent field, flip sign for codes 32..127.
    function automatic logic [31:0] lane_product(input logic [31:0] act, input logic [7:0] code);
        logic [31:0] ex;
        logic neg;
        ex = {24'd0, code & EXP_MASK} << EXP_SHIFT;
        neg = (code[7] == 1'b0) && (code[6:5] != 2'b00);
        return (act + ex) ^ (neg ? SIGN_BIT : 32'd0);
    endfunction

endpackage

[rtl/core/pwfm_fadd.sv]
// Combinational IEEE single adder, round to nearest even, subnormals kept.
`timescale 1ns / 1ps

module pwfm_fadd
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    logic        swap;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  ebig;
    logic [7:0]  esml;
    logic [23:0] mbig;
    logic [23:0] msml;
    logic [7:0]  d;
    logic [26:0] xa;
    logic [26:0] xs;
    logic [26:0] xsh;
    logic        lost;
    logic [27:0] sum;
    logic [26:0] mn;
    logic [9:0]  e;
    logic [9:0]  lz;
    logic [9:0]  sh;
    logic        rnd;
    logic [24:0] q;
    logic [31:0] res;

    always_comb
    begin
        swap = b[30:0] > a[30:0];
        big  = swap ? b : a;
        sml  = swap ? a : b;
        ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mbig = {big[30:23] != 8'd0, big[22:0]};
        msml = {sml[30:23] != 8'd0, sml[22:0]};
        d    = ebig - esml;
        xa   = {mbig, 3'b000};
        xs   = {msml, 3'b000};
        // sticky collects every bit shifted out; shifts of 27 or more leave only sticky
        lost = |(xs & ~({27{1'b1}} << d));
        xsh  = (xs >> d) | {26'd0, lost};
        sum  = (big[31] == sml[31]) ? ({1'b0, xa} + {1'b0, xsh}) : ({1'b0, xa} - {1'b0, xsh});
        e    = {2'b00, ebig};
        if (sum[27])
        begin
            mn = {sum[27:2], sum[1] | sum[0]};
            e  = e + 10'd1;
        end
        else
        begin
            mn = sum[26:0];
        end
        lz = 10'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (mn[i])
            begin
                lz = 10'(26 - i);
            end
        end
        sh  = (lz < (e - 10'd1)) ? lz : (e - 10'd1);
        mn  = mn << sh;
        e   = e - sh;
        rnd = mn[2] && ((mn[1:0] != 2'b00) || mn[3]);
        q   = {1'b0, mn[26:3]} + {24'd0, rnd};
        if (q[24])
        begin
            q = q >> 1;
            e = e + 10'd1;
        end
        if (e >= 10'd255)
        begin
            res = {big[31], 8'hFF, 23'd0};
        end
        else if (!q[23])
        begin
            res = {big[31], 8'd0, q[22:0]};
        end
        else
        begin
            res = {big[31], e[7:0], q[22:0]};
        end

        priority if (a[30:23] == 8'hFF && a[22:0] != 23'd0)
        begin
            y = a | 32'h0040_0000;
        end
        else if (b[30:23] == 8'hFF && b[22:0] != 23'd0)
        begin
            y = b | 32'h0040_0000;
        end
        else if (a[30:23] == 8'hFF)
        begin
            y = (b[30:23] == 8'hFF && a[31] != b[31]) ? 32'hFFC0_0000 : a;
        end
        else if (b[30:23] == 8'hFF)
        begin
            y = b;
        end
        else if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
        begin
            y = {a[31] & b[31], 31'd0};
        end
        else if (a[30:0] == 31'd0)
        begin
            y = b;
        end
        else if (b[30:0] == 31'd0)
        begin
            y = a;
        end
        else if (sum == 28'd0)
        begin
            y = 32'd0;
        end
        else
        begin
            y = res;
        end
    end

endmodule

[rtl/core/pot_weight_float_mac_row.sv]
// Top level of the power-of-two weight float MAC row.
`timescale 1ns / 1ps

// One step along k per cycle: an accepted step sits in an input register, and
// from there every lane adds its product into its accumulator with one
// combinational float adder per lane. A last step copies all lane sums into a
// drain register that hands out one sum per cycle unless out_ready is low, lane 0
// first, while the next run already accumulates. A last step waits in the input
// register only when the previous run's sums are still draining, so runs of at
// least LANES steps stream at one step per cycle while out_ready stays high.
module pot_weight_float_mac_row
    import pwfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] act_bits,
    input  logic [63:0] codes_low,
    input  logic [63:0] codes_high,
    input  logic        first_step,
    input  logic        last_step,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  lane,
    output logic [31:0] sum_bits,
    output logic        final_lane
);

    logic              stage_valid_reg;
    logic [31:0]       act_reg;
    logic [127:0]      codes_reg;
    logic              first_reg;
    logic              last_reg;
    logic [31:0]       acc_reg [LANES];
    logic [31:0]       acc_next [LANES];
    logic [31:0]       hold_reg [LANES];
    logic              drain_reg;
    logic [LANE_W-1:0] idx_reg;
    logic              out_xfer;
    logic              drain_free;
    logic              advance;

    assign out_xfer   = drain_reg && out_ready;
    assign drain_free = !drain_reg || (out_xfer && idx_reg == LANE_W'(LANES - 1));
    assign advance    = stage_valid_reg && (!last_reg || drain_free);
    assign in_ready   = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg   <= act_bits;
            codes_reg <= {codes_high, codes_low};
            first_reg <= first_step;
            last_reg  <= last_step;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [7:0]  code;
        logic [31:0] prod;
        logic [31:0] acc_in;

        if (i < CODE_LANES)
        begin : g_code
            assign code = codes_reg[8*i +: 8];
        end
        else
        begin : g_none
            assign code = 8'd0;
        end

        assign prod   = lane_product(act_reg, code);
        assign acc_in = first_reg ? 32'd0 : acc_reg[i];

        pwfm_fadd u_fadd
        (
            .a (acc_in),
            .b (prod),
            .y (acc_next[i])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                acc_reg[i] <= 32'd0;
            end
            else if (advance)
            begin
                acc_reg[i] <= acc_next[i];
            end
        end

        // drain line: loads on a last step, shifts toward lane 0 on each transfer
        always_ff @(posedge clk)
        begin
            if (advance && last_reg)
            begin
                hold_reg[i] <= acc_next[i];
            end
            else if (out_xfer)
            begin
                hold_reg[i] <= (i == LANES - 1) ? hold_reg[i] : hold_reg[(i + 1) % LANES];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (advance && last_reg)
        begin
            drain_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (out_xfer)
        begin
            drain_reg <= (idx_reg != LANE_W'(LANES - 1));
            idx_reg   <= idx_reg + LANE_W'(1);
        end
    end

    assign out_valid  = drain_reg;
    assign lane       = 4'(idx_reg);
    assign sum_bits   = hold_reg[0];
    assign final_lane = (idx_reg == LANE_W'(LANES - 1));

endmodule

[rtl/core/pwfm_checker.sv]
// Port-level checks on the result stream of the MAC row.
`timescale 1ns / 1ps

module pwfm_checker
    import pwfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  lane,
    input  logic [31:0] sum_bits,
    input  logic        final_lane
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lane) && $stable(sum_bits))
        else $error("result changed while stalled");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !final_lane |=> out_valid)
        else $error("run of sums broken before final lane");

    a_lane_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !final_lane |=> lane == $past(lane) + 4'd1)
        else $error("lane index did not advance by one");

    a_final_lane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_lane |-> lane == 4'(LANES - 1))
        else $error("final flag on wrong lane");

endmodule

bind pot_weight_float_mac_row pwfm_checker u_pwfm_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .lane       (lane),
    .sum_bits   (sum_bits),
    .final_lane (final_lane)
);

[dv/testbench.sv]
// Self-checking testbench for the power-of-two weight float MAC row.
`timescale 1ns / 1ps

module testbench;
    import pwfm_pkg::*;

    typedef struct packed {
        logic [31:0] act;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        first;
        logic        last;
    } step_t;

    typedef struct packed {
        logic [3:0]  lane;
        logic [31:0] sum;
        logic        fin;
    } lane_sum_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] act_bits;
    logic [63:0] codes_low;
    logic [63:0] codes_high;
    logic        first_step;
    logic        last_step;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  lane;
    logic [31:0] sum_bits;
    logic        final_lane;

    step_t       pending_steps[$];
    lane_sum_t   expected_sums[$];
    logic [31:0] model_acc[16];
    int          errors;
    int          send_gap;
    int          recv_gap;
    bit          hold_recv;
    bit          pause_send;

    pot_weight_float_mac_row uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // IEEE single add, round to nearest even, subnormals kept
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] t, q, lo32;
        logic [7:0]  ea, eb;
        logic [22:0] fa, fb;
        logic        sa, sb, sg;
        logic [63:0] ma, mb, m, lost;
        int          e, d;
        ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
        sa = a[31]; sb = b[31];
        if (ea == 8'hFF && fa != 0) return a | 32'h0040_0000;
        if (eb == 8'hFF && fb != 0) return b | 32'h0040_0000;
        if (ea == 8'hFF)
        begin
            if (eb == 8'hFF && sa != sb) return 32'hFFC0_0000;
            return a;
        end
        if (eb == 8'hFF) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {sa & sb, 31'd0};
        if (a[30:0] == 0) return b;
        if (b[30:0] == 0) return a;
        if (b[30:0] > a[30:0])
        begin
            t = a; a = b; b = t;
            ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
            sa = a[31]; sb = b[31];
        end
        sg = sa;
        ma = {8'd0, (ea != 0), fa, 32'd0};
        mb = {8'd0, (eb != 0), fb, 32'd0};
        if (ea == 0) ea = 8'd1;
        if (eb == 0) eb = 8'd1;
        d = ea - eb;
        if (d > 56) mb = 64'd1;
        else if (d > 0)
        begin
            lost = mb & ((64'd1 << d) - 1);
            mb = (mb >> d) | (lost != 0);
        end
        m = (sa == sb) ? ma + mb : ma - mb;
        if (m == 0) return 32'd0;
        e = ea;
        if (m >= (64'd1 << 56))
        begin
            m = (m >> 1) | (m & 1);
            e++;
        end
        while (m < (64'd1 << 55) && e > 1)
        begin
            m = m << 1;
            e--;
        end
        q = m[63:32];
        lo32 = m[31:0];
        if (lo32 > 32'h8000_0000 || (lo32 == 32'h8000_0000 && q[0])) q++;
        if (q >= 32'h0100_0000)
        begin
            q = q >> 1;
            e++;
        end
        if (e >= 255) return {sg, 31'h7F80_0000};
        if (q < 32'h0080_0000) return {sg, q[30:0]};
        return {sg, e[7:0], q[22:0]};
    endfunction

    task automatic accumulate_step(input step_t s);
        logic [7:0]  code;
        logic [31:0] prod;
        logic        neg;
        lane_sum_t   r;
        for (int i = 0; i < 16; i++)
        begin
            code = (i < 8) ? s.lo[8*i +: 8] : s.hi[8*(i-8) +: 8];
            neg = (code >= 8'd32) && (code <= 8'd127);
            prod = (s.act + ({24'd0, code & 8'h1F} << 23)) ^ {neg, 31'd0};
            if (s.first) model_acc[i] = 32'd0;
            model_acc[i] = fp_add(model_acc[i], prod);
        end
        if (s.last)
            for (int i = 0; i < 16; i++)
            begin
                r.lane = i[3:0];
                r.sum = model_acc[i];
                r.fin = (i == 15);
                expected_sums.push_back(r);
            end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] rand_act();
        case ($urandom_range(0, 9))
            0: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom)};
            1: return {1'($urandom_range(0, 1)), 8'h00, 23'($urandom)};
            2: return {1'($urandom_range(0, 1)), 8'($urandom_range(220, 254)), 23'($urandom)};
            3: return $urandom;
            default: return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 150)),
                             23'($urandom)};
        endcase
    endfunction

    function automatic logic [63:0] rand_codes();
        logic [63:0] c;
        for (int i = 0; i < 8; i++)
            c[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
        return c;
    endfunction

    function automatic step_t mk(input logic [31:0] a, input logic [63:0] l, input logic [63:0] h,
                                 input logic f, input logic z);
        step_t s;
        s.act = a; s.lo = l; s.hi = h; s.first = f; s.last = z;
        return s;
    endfunction

    // driver: model updates at the accepting edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accumulate_step(pending_steps.pop_front());
            end
            if (!(in_valid && !in_ready))
            begin
                if (send_gap > 0 || pause_send || pending_steps.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end
                else
                begin
                    in_valid <= 1'b1;
                    act_bits <= pending_steps[0].act;
                    codes_low <= pending_steps[0].lo;
                    codes_high <= pending_steps[0].hi;
                    first_step <= pending_steps[0].first;
                    last_step <= pending_steps[0].last;
                    if ($urandom_range(0, 2) == 0)
                        send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                                : $urandom_range(0, 2);
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        lane_sum_t w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_sums.size() == 0)
                    report("unexpected transfer", sum_bits, 32'd0);
                else
                begin
                    w = expected_sums.pop_front();
                    if (lane !== w.lane) report("lane", lane, w.lane);
                    if (sum_bits !== w.sum) report("sum_bits", sum_bits, w.sum);
                    if (final_lane !== w.fin) report("final_lane", final_lane, w.fin);
                end
            end
            if (hold_recv) out_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                            : $urandom_range(0, 2);
            end
        end
    end

    initial
    begin
        int len;
        errors = 0;
        hold_recv = 0;
        pause_send = 0;
        foreach (model_acc[i]) model_acc[i] = 32'd0;
        in_valid = 0; out_ready = 0;
        act_bits = 0; codes_low = 0; codes_high = 0; first_step = 0; last_step = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no first step after reset, code extremes, NaN/inf, cancel
        pending_steps.push_back(mk(32'h3F80_0000, 64'h7F60_3F20_1F00_FF80,
                                   64'h0102_4041_6162_E0A0, 1'b0, 1'b1));
        pending_steps.push_back(mk(32'h7F80_0000, 64'h0, 64'h2020_2020_2020_2020, 1'b1, 1'b0));
        pending_steps.push_back(mk(32'h7F80_0000, 64'h2020_2020_0000_0000, 64'h0, 1'b0, 1'b1));
        pending_steps.push_back(mk(32'h7FA0_0001, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 1'b1));
        pending_steps.push_back(mk(32'h0000_0001, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0));
        pending_steps.push_back(mk(32'h8000_0001, 64'h0, 64'h0, 1'b0, 1'b1));
        pending_steps.push_back(mk(32'h7F7F_FFFF, 64'h1F1F_1F1F_0101_0101, 64'h0, 1'b1, 1'b0));
        pending_steps.push_back(mk(32'h7F7F_FFFF, 64'h0101_0101, 64'h0, 1'b0, 1'b1));
        pending_steps.push_back(mk(32'h3F80_0000, 64'h0, 64'h0, 1'b1, 1'b0));
        pending_steps.push_back(mk(32'h3F80_0000, 64'h2020_2020_2020_2020, 64'h2020, 1'b0, 1'b1));
        pending_steps.push_back(mk(32'h8000_0000, 64'h2020_2020, 64'h0, 1'b1, 1'b1));
        pending_steps.push_back(mk(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
        wait (pending_steps.size() == 0);

        // receiver holds off long while sender keeps offering
        hold_recv = 1;
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 4; k++)
                pending_steps.push_back(mk(rand_act(), rand_codes(), rand_codes(),
                                           k == 0, k == 3));
        repeat (200) @(posedge clk);
        hold_recv = 0;
        wait (pending_steps.size() == 0);

        // sender pauses until everything has drained
        pause_send = 1;
        wait (expected_sums.size() == 0);
        pause_send = 0;

        while (pending_steps.size() < 90)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                pending_steps.push_back(mk(rand_act(), rand_codes(), rand_codes(),
                                           (k == 0) && ($urandom_range(0, 9) != 0),
                                           k == len - 1));
            if ($urandom_range(0, 5) == 0)
                pending_steps.push_back(mk(rand_act(), rand_codes(), rand_codes(),
                                           1'($urandom_range(0, 1)), 1'b0));
        end
        pending_steps.push_back(mk(rand_act(), rand_codes(), rand_codes(), 1'b1, 1'b1));
        wait (pending_steps.size() == 0);
        wait (expected_sums.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule
